FILE: rtl/tkpa_pkg.sv
// shared types and constants for the touch key autorepeat block
// field widths, event kinds, configuration register indexes; no dependencies
package tkpa_pkg;

    localparam int KEY_W     = 6;
    localparam int READ_W    = 22;
    localparam int TIME_W    = 32;
    localparam int RATIO_W   = 6;
    localparam int DELAY_W   = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W  = 88;
    localparam int M_DATA_W  = 8;

    // reset values of the configuration registers, and the reading scale
    localparam logic [RATIO_W-1:0] RATIO_RESET   = 6'd11;
    localparam logic [DELAY_W-1:0] DELAY_RESET   = 16'd500;
    localparam logic [DELAY_W-1:0] PERIOD_RESET  = 16'd100;
    localparam logic [3:0]         READ_SCALE    = 4'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO  = 8'd0,
        CFG_DELAY  = 8'd1,
        CFG_PERIOD = 8'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_DOWN  = 2'd0,
        KIND_UP    = 2'd1,
        KIND_TYPED = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic              last;
        event_kind_t       kind;
        logic [KEY_W-1:0]  key;
    } event_t;

endpackage

FILE: rtl/tkpa_stamp_ram.sv
// per-key timestamp memory, one write port and one registered read port
// depends on nothing
module tkpa_stamp_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/tkpa_event_queue.sv
// two-deep event buffer in front of the result channel
// takes one or two events per push; uses tkpa_pkg
module tkpa_event_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  logic            push_two,
    input  tkpa_pkg::event_t ev0,
    input  tkpa_pkg::event_t ev1,
    output logic            can_push,
    output logic            m_valid,
    input  logic            m_ready,
    output tkpa_pkg::event_t m_event
);
    import tkpa_pkg::*;

    logic   out_valid_reg, out_valid_next;
    logic   pend_valid_reg, pend_valid_next;
    event_t out_ev_reg, out_ev_next;
    event_t pend_ev_reg, pend_ev_next;

    assign can_push = !out_valid_reg || (m_ready && !pend_valid_reg);

    always_comb begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        out_ev_next     = out_ev_reg;
        pend_ev_next    = pend_ev_reg;
        if (out_valid_reg && m_ready) begin
            if (pend_valid_reg) begin
                out_ev_next     = pend_ev_reg;
                pend_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (push) begin
            out_valid_next = 1'b1;
            out_ev_next    = ev0;
            if (push_two) begin
                pend_valid_next = 1'b1;
                pend_ev_next    = ev1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_ev_reg  <= out_ev_next;
        pend_ev_reg <= pend_ev_next;
    end

    assign m_valid = out_valid_reg;
    assign m_event = out_ev_reg;

    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> out_valid_reg)
        else $error("second event buffered without a first");
    a_not_last_has_follower: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ev_reg.last) |-> pend_valid_reg)
        else $error("non-final event without its follower");
    a_push_only_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> can_push)
        else $error("push into a full buffer");

endmodule

FILE: rtl/touch_key_press_autorepeat.sv
// touch key press detector with autorepeat, top level
// uses tkpa_pkg, tkpa_stamp_ram and tkpa_event_queue
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata: key, reading, baseline, time
//  m_        out  m_tvalid/m_tready    m_tdata: key, kind; m_tlast: last event
//  cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one sample per cycle unless stalled: the stamp memory is read in the accept
// cycle, the key is evaluated in the next one and written back as it leaves
// a new touch gives two events, so the next sample with an event waits until
// the two-deep event buffer has room again; samples with no event never wait
// reset clears all pressed bits at once, no clearing pass; stamps stay undefined
// a stalled result channel holds the evaluation stage, which holds the input
module touch_key_press_autorepeat #(
    parameter int NUM_KEYS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // key_index[5:0], raw_reading[27:6], baseline[49:28], time_ms[81:50], zero fill
    input  logic [tkpa_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // event_key[5:0], event_kind[7:6]
    output logic [tkpa_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tkpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tkpa_pkg::CFG_DAT_W-1:0] cfg_data
);
    import tkpa_pkg::*;

    localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CMP_W  = 9;
    localparam int PR_W   = READ_W + 4;
    localparam int PB_W   = READ_W + RATIO_W;

    // configuration
    logic [RATIO_W-1:0] ratio_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [DELAY_W-1:0] period_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg  <= RATIO_RESET;
            delay_reg  <= DELAY_RESET;
            period_reg <= PERIOD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RATIO:  ratio_reg  <= cfg_data[RATIO_W-1:0];
                CFG_DELAY:  delay_reg  <= cfg_data;
                CFG_PERIOD: period_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // input beat fields
    logic [KEY_W-1:0]  in_key;
    logic [READ_W-1:0] in_read;
    logic [READ_W-1:0] in_base;
    logic [TIME_W-1:0] in_time;
    logic              in_range;
    logic              s_accept;

    assign in_key   = s_tdata[5:0];
    assign in_read  = s_tdata[27:6];
    assign in_base  = s_tdata[49:28];
    assign in_time  = s_tdata[81:50];
    assign in_range = CMP_W'(in_key) < CMP_W'(NUM_KEYS);
    assign s_accept = s_tvalid && s_tready;

    // evaluation stage
    logic              s1_valid_reg;
    logic [KEY_W-1:0]  s1_key_reg;
    logic [READ_W-1:0] s1_read_reg;
    logic [READ_W-1:0] s1_base_reg;
    logic [TIME_W-1:0] s1_time_reg;
    logic              s1_fire;
    logic [KEY_AW-1:0] s1_addr;

    assign s_tready = !s1_valid_reg || s1_fire;
    assign s1_addr  = KEY_AW'(s1_key_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_accept && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_key_reg  <= in_key;
            s1_read_reg <= in_read;
            s1_base_reg <= in_base;
            s1_time_reg <= in_time;
        end
    end

    // stamp memory with one-entry forwarding of the write that lands
    // at the same edge as the read
    logic              st_wr_en;
    logic [TIME_W-1:0] st_wr_data;
    logic [TIME_W-1:0] st_rd_data;
    logic              fwd_valid_reg;
    logic [KEY_AW-1:0] fwd_addr_reg;
    logic [TIME_W-1:0] fwd_data_reg;

    tkpa_stamp_ram #(
        .DEPTH (NUM_KEYS),
        .AW    (KEY_AW),
        .DW    (TIME_W)
    ) u_stamp_ram (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (s1_addr),
        .wr_data (st_wr_data),
        .rd_en   (s_accept && in_range),
        .rd_addr (KEY_AW'(in_key)),
        .rd_data (st_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (s_accept) begin
            fwd_valid_reg <= st_wr_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= st_wr_data;
        end
    end

    // pressed bits in flops, cleared by reset
    logic              flags_reg [NUM_KEYS];
    logic              flag_wr_en;
    logic              flag_wr_val;
    logic              pressed;

    assign pressed = flags_reg[s1_addr];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                flags_reg[i] <= 1'b0;
            end
        end else if (flag_wr_en) begin
            flags_reg[s1_addr] <= flag_wr_val;
        end
    end

    // touch test and held-time check
    logic [PR_W-1:0]    prod_read;
    logic [PB_W-1:0]    prod_base;
    logic               touched;
    logic [TIME_W-1:0]  stamp;
    logic [TIME_W-1:0]  elapsed;
    logic               due;
    logic [DELAY_W-1:0] offset;

    assign prod_read = PR_W'(s1_read_reg) * PR_W'(READ_SCALE);
    assign prod_base = PB_W'(s1_base_reg) * PB_W'(ratio_reg);
    assign touched   = PB_W'(prod_read) > prod_base;
    assign stamp     = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg : st_rd_data;
    assign elapsed   = s1_time_reg - stamp;
    assign due       = elapsed > TIME_W'(delay_reg);
    // repeats fall back to once per initial delay when the period is longer
    assign offset    = (delay_reg > period_reg) ? delay_reg - period_reg : '0;

    // event decision
    logic   has_event;
    logic   two_events;
    logic   q_can_push;
    event_t ev0;
    event_t ev1;
    logic   st_set;

    always_comb begin
        has_event   = 1'b0;
        two_events  = 1'b0;
        flag_wr_val = 1'b0;
        st_set      = 1'b0;
        st_wr_data  = s1_time_reg;
        ev0         = '{last: 1'b1, kind: KIND_TYPED, key: s1_key_reg};
        ev1         = '{last: 1'b1, kind: KIND_TYPED, key: s1_key_reg};
        if (touched && !pressed) begin
            // new touch: key_down then typed
            has_event   = 1'b1;
            two_events  = 1'b1;
            flag_wr_val = 1'b1;
            st_set      = 1'b1;
            ev0         = '{last: 1'b0, kind: KIND_DOWN, key: s1_key_reg};
        end else if (touched && due) begin
            // held past the delay: repeat
            has_event   = 1'b1;
            flag_wr_val = 1'b1;
            st_set      = 1'b1;
            st_wr_data  = s1_time_reg - TIME_W'(offset);
        end else if (!touched && pressed) begin
            has_event = 1'b1;
            ev0       = '{last: 1'b1, kind: KIND_UP, key: s1_key_reg};
        end
    end

    assign s1_fire    = s1_valid_reg && (!has_event || q_can_push);
    assign st_wr_en   = s1_fire && st_set;
    assign flag_wr_en = s1_fire && has_event;

    event_t m_event;

    tkpa_event_queue u_event_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s1_fire && has_event),
        .push_two (two_events),
        .ev0      (ev0),
        .ev1      (ev1),
        .can_push (q_can_push),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_event  (m_event)
    );

    assign m_tdata = {m_event.kind, m_event.key};
    assign m_tlast = m_event.last;

    a_down_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_event.kind == KIND_DOWN) |-> !m_tlast)
        else $error("key_down beat marked final");
    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_key_reg)))
        else $error("evaluation stage changed while stalled");
    a_new_touch_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && two_events) |=> flags_reg[$past(s1_addr)])
        else $error("pressed bit not set after new touch");
    a_release_clears_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && has_event && !touched) |=> !flags_reg[$past(s1_addr)])
        else $error("pressed bit still set after release");

endmodule

FILE: dv/tkpa_event_checker.sv
// event checker for the touch key autorepeat block: watches sample, register and event beats
// keeps its own pressed bits, hold stamps and register copies; depends on tkpa_pkg
module tkpa_event_checker #(
    parameter int NUM_KEYS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tkpa_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tkpa_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           m_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tkpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tkpa_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending,
    output int                             samples_seen,
    output int                             events_seen
);
    import tkpa_pkg::*;

    localparam int MAX_REPORTS = 10;

    logic [NUM_KEYS-1:0] key_held;
    logic [TIME_W-1:0]   hold_ref [NUM_KEYS];
    logic [RATIO_W-1:0]  ratio_tenths;
    logic [DELAY_W-1:0]  delay_ms;
    logic [DELAY_W-1:0]  period_ms;
    event_t              due_events [$];
    int                  errors;
    int                  n_samples;
    int                  n_events;

    task automatic push_event(input logic [KEY_W-1:0] key, input event_kind_t kind,
                              input logic last);
        event_t ev;
        ev.key  = key;
        ev.kind = kind;
        ev.last = last;
        due_events.push_back(ev);
    endtask

    // one sample beat: touch test, then press, hold/repeat or release
    task automatic evaluate_touch(input logic [S_DATA_W-1:0] beat);
        logic [KEY_W-1:0]   key;
        logic [READ_W-1:0]  reading;
        logic [READ_W-1:0]  base;
        logic [TIME_W-1:0]  now;
        logic [TIME_W-1:0]  elapsed;
        logic [DELAY_W-1:0] offset;
        longint unsigned    lhs;
        longint unsigned    rhs;
        key     = beat[KEY_W-1:0];
        reading = beat[KEY_W +: READ_W];
        base    = beat[KEY_W+READ_W +: READ_W];
        now     = beat[KEY_W+2*READ_W +: TIME_W];
        if (key >= NUM_KEYS) return;
        lhs = 64'(reading) * 64'(READ_SCALE);
        rhs = 64'(base) * 64'(ratio_tenths);
        if (lhs > rhs) begin
            if (!key_held[key]) begin
                key_held[key] = 1'b1;
                hold_ref[key] = now;
                push_event(key, KIND_DOWN, 1'b0);
                push_event(key, KIND_TYPED, 1'b1);
            end else begin
                elapsed = now - hold_ref[key];
                if (elapsed > {16'd0, delay_ms}) begin
                    // offset saturates at zero when the period is above the delay
                    offset = (delay_ms > period_ms) ? delay_ms - period_ms : '0;
                    hold_ref[key] = now - {16'd0, offset};
                    push_event(key, KIND_TYPED, 1'b1);
                end
            end
        end else if (key_held[key]) begin
            key_held[key] = 1'b0;
            push_event(key, KIND_UP, 1'b1);
        end
    endtask

    always @(posedge aclk) begin : watch
        event_t want;
        if (!aresetn) begin
            key_held     = '0;
            ratio_tenths = RATIO_RESET;
            delay_ms     = DELAY_RESET;
            period_ms    = PERIOD_RESET;
            due_events.delete();
            errors    = 0;
            n_samples = 0;
            n_events  = 0;
        end else begin
            // compare before predicting, an event never leaves in its sample's cycle
            if (m_tvalid && m_tready) begin
                n_events++;
                if (due_events.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected event: key %0d kind %0d last %0b",
                                 m_tdata[KEY_W-1:0], m_tdata[KEY_W +: 2], m_tlast);
                end else begin
                    want = due_events.pop_front();
                    if (m_tdata[KEY_W-1:0] !== want.key || m_tdata[KEY_W +: 2] !== want.kind ||
                        m_tlast !== want.last) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("event mismatch: expected key %0d kind %0d last %0b, got key %0d kind %0d last %0b",
                                     want.key, want.kind, want.last, m_tdata[KEY_W-1:0],
                                     m_tdata[KEY_W +: 2], m_tlast);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RATIO:  ratio_tenths = cfg_data[RATIO_W-1:0];
                    CFG_DELAY:  delay_ms     = cfg_data[DELAY_W-1:0];
                    CFG_PERIOD: period_ms    = cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                n_samples++;
                evaluate_touch(s_tdata);
            end
        end
        fail_count   <= errors;
        pending      <= due_events.size();
        samples_seen <= n_samples;
        events_seen  <= n_events;
    end

endmodule

FILE: dv/touch_key_press_autorepeat_tb.sv
// testbench top for the touch key autorepeat block: clock, reset, sample and register stimulus
// depends on tkpa_pkg, touch_key_press_autorepeat and tkpa_event_checker
module touch_key_press_autorepeat_tb;
    import tkpa_pkg::*;

    localparam int          NUM_KEYS       = 64;
    localparam int          CLK_HALF       = 6;
    localparam int          TIMEOUT_CYCLES = 600000;
    localparam int          IDLE_PCT       = 31;
    localparam int          ITEMS_PER_SET  = 210;
    localparam int unsigned READ_MAX       = 4194303;
    // register indexes that the block has no register for
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 8'hFF;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int samples_seen;
    int events_seen;

    // pacing: chance in a hundred that a side sits out a cycle
    int tx_idle_pct = IDLE_PCT;
    int rx_idle_pct = IDLE_PCT;

    // register values as last written, only used to shape the stimulus
    logic [RATIO_W-1:0] cur_ratio  = RATIO_RESET;
    logic [DELAY_W-1:0] cur_delay  = DELAY_RESET;
    logic [DELAY_W-1:0] cur_period = PERIOD_RESET;
    logic [TIME_W-1:0]  now_ms     = '0;
    int                 n_settings = 1;

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    touch_key_press_autorepeat #(
        .NUM_KEYS (NUM_KEYS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tkpa_event_checker #(
        .NUM_KEYS (NUM_KEYS)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .samples_seen (samples_seen),
        .events_seen  (events_seen)
    );

    // event side: random backpressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one sample beat; the random gap comes first so tvalid is never dropped and
    // raised in the same step, then hold until the block takes the beat
    task automatic send_sample(input logic [KEY_W-1:0] key, input logic [READ_W-1:0] reading,
                               input logic [READ_W-1:0] base, input logic [TIME_W-1:0] t_ms);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {{(S_DATA_W-KEY_W-2*READ_W-TIME_W){1'b0}}, t_ms, base, reading, key};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // one register beat, valid dropped in a step of its own afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [CFG_DAT_W-1:0] ratio_word,
                             input logic [DELAY_W-1:0] delay, input logic [DELAY_W-1:0] period);
        write_reg(CFG_RATIO, ratio_word);
        write_reg(CFG_DELAY, delay);
        write_reg(CFG_PERIOD, period);
        cur_ratio  = ratio_word[RATIO_W-1:0];
        cur_delay  = delay;
        cur_period = period;
        n_settings++;
    endtask

    // stop sending and wait until every predicted event is out; a sample with no
    // event may still sit in the evaluation stage, so the task waits on after that
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // baseline that still leaves room for a touching reading when asked,
    // half of the time a small pad count
    function automatic logic [READ_W-1:0] pick_base(input bit touch);
        int unsigned top_base;
        top_base = touch ? (READ_MAX * 10 - 1) / cur_ratio : READ_MAX;
        if (top_base > READ_MAX) top_base = READ_MAX;
        if ($urandom_range(1) == 0 && top_base > 4095) top_base = 4095;
        return READ_W'($urandom_range(top_base, 0));
    endfunction

    // reading on the wanted side of the threshold; tight puts it right at the edge
    function automatic logic [READ_W-1:0] pick_reading(input logic [READ_W-1:0] base,
                                                       input bit touch, input bit tight);
        int unsigned level;
        level = 32'(base);
        level = level * cur_ratio / 10;
        if (touch) begin
            level = level + 1;
            return tight ? READ_W'(level) : READ_W'($urandom_range(READ_MAX, level));
        end
        if (level > READ_MAX) level = READ_MAX;
        return tight ? READ_W'(level) : READ_W'($urandom_range(level, 0));
    endfunction

    // mostly press/hold/release traffic on a few keys with time moving forward,
    // the rest fully random samples at random times
    task automatic run_traffic(input int n_items);
        logic [KEY_W-1:0]  keys [4];
        logic [READ_W-1:0] base;
        bit                touch;
        int unsigned       step_max;
        int                i;
        for (i = 0; i < 4; i++) keys[i] = KEY_W'($urandom);
        step_max = cur_delay / 3 + cur_period / 2 + 2;
        // half of the sets start just short of the time wrap
        if ($urandom_range(1) == 0) now_ms = $urandom;
        else now_ms = 32'hFFFF_FFFF - $urandom_range(4 * cur_delay, 0);
        for (i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 5) keys[2'($urandom_range(3))] = KEY_W'($urandom);
            if ($urandom_range(99) < 12) begin
                send_sample(KEY_W'($urandom), READ_W'($urandom), READ_W'($urandom), $urandom);
            end else begin
                touch  = ($urandom_range(99) < 78);
                now_ms = now_ms + $urandom_range(step_max, 0);
                base   = pick_base(touch);
                send_sample(keys[2'($urandom_range(3))],
                            pick_reading(base, touch, $urandom_range(99) < 10), base, now_ms);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset settings: ratio 1.1, delay 500, repeat 100
        // touch at time zero, then hold exactly at the delay and one past it
        send_sample(6'd0, 22'd12, 22'd10, 32'd0);
        send_sample(6'd0, 22'h3FFFFF, 22'd0, 32'd500);
        send_sample(6'd0, 22'h3FFFFF, 22'd0, 32'd501);
        // repeat period: stamp now at 101, first repeat only past 601
        send_sample(6'd0, 22'd100, 22'd1, 32'd601);
        send_sample(6'd0, 22'd100, 22'd1, 32'd602);
        // zero reading on zero baseline is not a touch: release, then no further event
        send_sample(6'd0, 22'd0, 22'd0, 32'd700);
        send_sample(6'd0, 22'd0, 22'd0, 32'd800);
        // reading exactly at the threshold is not a touch, one count above is
        send_sample(6'd63, 22'd11, 22'd10, 32'd1000);
        send_sample(6'd63, 22'd12, 22'd10, 32'd1000);
        send_sample(6'd63, 22'h3FFFFF, 22'h3FFFFF, 32'd1001);
        // hold across the time wrap
        send_sample(6'd5, 22'd3000, 22'd2000, 32'hFFFF_FF00);
        send_sample(6'd5, 22'd3000, 22'd2000, 32'h0000_00F4);
        send_sample(6'd5, 22'd3000, 22'd2000, 32'h0000_00F5);
        // time going back before the wrap: the stamp sits just below it, so no repeat
        send_sample(6'd5, 22'h3FFFFF, 22'd1, 32'hFFFF_FFFF);
        send_sample(6'd5, 22'd0, 22'h3FFFFF, 32'hFFFF_FFFF);
        // two keys held at once, released in turn
        send_sample(6'd42, 22'd2000000, 22'd1234567, 32'd7);
        send_sample(6'd21, 22'd2000000, 22'd1234567, 32'd7);
        send_sample(6'd42, 22'd1, 22'h3FFFFF, 32'd8);
        send_sample(6'd21, 22'd1, 22'h3FFFFF, 32'd8);
        settle();
        run_traffic(ITEMS_PER_SET);
        settle();

        // lowest settings, with no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(16'd10, 16'd1, 16'd1);
        run_traffic(ITEMS_PER_SET);
        settle();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;

        // highest settings
        configure(16'd40, 16'hFFFF, 16'hFFFF);
        run_traffic(ITEMS_PER_SET);
        settle();

        // repeat period above the initial delay
        configure(16'd23, 16'd300, 16'd700);
        run_traffic(ITEMS_PER_SET);
        settle();

        // writes to unused indexes do nothing; ratio word with junk above its field
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h1234);
        configure(16'hFFCB, 16'd50, 16'd20);
        run_traffic(ITEMS_PER_SET);
        settle();

        // long delay with the shortest repeat
        configure(16'd10, 16'hFFFF, 16'd1);
        run_traffic(ITEMS_PER_SET);
        settle();

        // a random setting inside the allowed ranges
        begin : random_setting
            logic [DELAY_W-1:0] d;
            d = DELAY_W'($urandom_range(2000, 1));
            configure(CFG_DAT_W'($urandom_range(40, 10)), d, DELAY_W'($urandom_range(d, 1)));
        end
        run_traffic(ITEMS_PER_SET);
        settle();

        // reset values written back explicitly
        configure({{(CFG_DAT_W-RATIO_W){1'b0}}, RATIO_RESET}, DELAY_RESET, PERIOD_RESET);
        run_traffic(ITEMS_PER_SET);
        settle();

        $display("covered %0d touch samples and %0d key events over %0d register settings,",
                 samples_seen, events_seen, n_settings);
        $display("with press, hold, repeat, release, time wrap and random pacing on both sides");
        if (pending != 0)
            $display("%0d predicted events never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("run did not finish in %0d cycles", TIMEOUT_CYCLES);
        $display("FAILURE");
        $finish;
    end

endmodule
